// ===== rtl/core/dnle_pkg.sv =====
`timescale 1ns / 1ps

package dnle_pkg;

  // Largest label the buffer holds; longer labels are truncated.
  localparam int MaxLabelDefault = 62;

  // Character that ends a label in the dotted form.
  localparam logic [7:0] DotChar = 8'h2E;

  // Byte that ends a name in wire form.
  localparam logic [7:0] TermByte = 8'h00;

  localparam int ByteW = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_READ,
    ST_EMIT,
    ST_TERM
  } dnle_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_char;
    logic read_char;
    logic load_len;
    logic load_char;
    logic load_term;
    logic last;
    logic clear_label;
  } dnle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_dot;
    logic label_empty;
    logic read_last;
    logic out_free;
  } dnle_sts_t;

endpackage

// ===== rtl/core/dnle_datapath.sv =====
`timescale 1ns / 1ps

module dnle_datapath
  import dnle_pkg::*;
#(
  parameter int MaxLabel = MaxLabelDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ByteW-1:0] in_byte_i,
  input  dnle_cmd_t        cmd_i,
  output dnle_sts_t        sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             is_length_o,
  output logic             last_of_run_o,
  output logic             label_overflow_o
);

  localparam int CntW  = $clog2(MaxLabel + 1);
  localparam int AddrW = (MaxLabel > 1) ? $clog2(MaxLabel) : 1;

  logic [ByteW-1:0] label_mem [MaxLabel];
  logic [ByteW-1:0] rd_data_q;

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             ovf_q, ovf_d;
  logic             full;
  logic             mem_we;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             is_length_q;
  logic             last_q;
  logic             ovf_out_q;
  logic             any_load;
  logic [ByteW-1:0] load_byte;

  assign full   = (count_q == CntW'(MaxLabel));
  assign mem_we = cmd_i.store_char && !full;

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    if (cmd_i.store_char) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
    if (cmd_i.read_char) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.clear_label) begin
      count_d = '0;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      label_mem[count_q[AddrW-1:0]] <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_char) begin
      rd_data_q <= label_mem[idx_q[AddrW-1:0]];
    end
  end

  // Output register.
  assign any_load = cmd_i.load_len || cmd_i.load_char || cmd_i.load_term;

  always_comb begin
    if (cmd_i.load_len) begin
      load_byte = {{(ByteW - CntW){1'b0}}, count_q};
    end else if (cmd_i.load_char) begin
      load_byte = rd_data_q;
    end else begin
      load_byte = TermByte;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (any_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (any_load) begin
      out_byte_q  <= load_byte;
      is_length_q <= cmd_i.load_len;
      last_q      <= cmd_i.last;
      ovf_out_q   <= ovf_q;
    end
  end

  assign sts_o.is_dot      = (in_byte_i == DotChar);
  assign sts_o.label_empty = (count_q == '0);
  assign sts_o.read_last   = (idx_q == count_q);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign is_length_o      = is_length_q;
  assign last_of_run_o    = last_q;
  assign label_overflow_o = ovf_out_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxLabel))
    else $error("label count exceeds the buffer depth");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= count_q)
    else $error("read index passed the label count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !any_load)
    else $error("output register loaded while its word is stalled");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared without reset");
`endif

endmodule

// ===== rtl/core/dnle_ctrl.sv =====
`timescale 1ns / 1ps

module dnle_ctrl
  import dnle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      end_of_name_i,
  input  dnle_sts_t sts_i,
  output dnle_cmd_t cmd_o
);

  dnle_state_e state_q, state_d;
  logic        eon_q, eon_d;
  logic        accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      eon_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      eon_q   <= eon_d;
    end
  end

  always_comb begin
    state_d = state_q;
    eon_d   = eon_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (end_of_name_i || sts_i.is_dot) begin
            eon_d   = end_of_name_i;
            state_d = ST_LEN;
          end else begin
            cmd_o.store_char = 1'b1;
          end
        end
      end
      ST_LEN: begin
        if (sts_i.out_free) begin
          cmd_o.load_len = 1'b1;
          if (sts_i.label_empty) begin
            cmd_o.last        = !eon_q;
            cmd_o.clear_label = 1'b1;
            state_d           = eon_q ? ST_TERM : ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.read_char = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_char = 1'b1;
          if (sts_i.read_last) begin
            cmd_o.last        = !eon_q;
            cmd_o.clear_label = 1'b1;
            state_d           = eon_q ? ST_TERM : ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_TERM: begin
        if (sts_i.out_free) begin
          cmd_o.load_term = 1'b1;
          cmd_o.last      = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/dns_name_label_encoder_unit.sv =====
`timescale 1ns / 1ps

// DNS name label encoder. Host name characters arrive one word at a time on
// the input channel (in_valid_i / in_stall_o); wire-form bytes leave on the
// output channel (out_valid_o / out_stall_i). An ordinary character is
// buffered and produces nothing. A dot flushes the buffered label as a
// length word followed by its characters, and an end-of-name word does the
// same and then adds a zero terminator. Once a dot or end-of-name is
// accepted, the sequencer moves to its length state, which loads the length
// word into the output register as soon as that register is free. The
// label buffer is a memory with a registered read, so each buffered
// character is first read and then loaded into the output register. The
// input is stalled for the whole flush.
// Reset clears the state machine, the label count, the sticky overflow flag
// and the output valid; the buffer contents need no clearing since only
// written entries are ever read. When the receiver stalls, the output word
// holds and the flush waits; characters can still be accepted while the
// last word of a flush waits in the output register.
module dns_name_label_encoder_unit
  import dnle_pkg::*;
#(
  parameter int MaxLabel = MaxLabelDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             end_of_name_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             is_length_o,
  output logic             last_of_run_o,
  output logic             label_overflow_o
);

  // Command and status between the sequencer and the datapath.
  dnle_cmd_t cmd;
  dnle_sts_t sts;

  // The sequencer decides which word goes out next and when the label is done.
  dnle_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .end_of_name_i (end_of_name_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // The datapath holds the label buffer, its count, the overflow flag and
  // the output register.
  dnle_datapath #(
    .MaxLabel (MaxLabel)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_byte_i        (in_byte_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .is_length_o      (is_length_o),
    .last_of_run_o    (last_of_run_o),
    .label_overflow_o (label_overflow_o)
  );

endmodule
